>>> sv/rsst_pkg.sv
// rsst_pkg: word types and codes for the range sum segment tree
// used by range_sum_segment_tree_top; no dependencies
`timescale 1ns / 1ps

package rsst_pkg;

   localparam int DATA_W = 32;
   localparam int IDX_W  = 10;
   localparam int SIZE_W = 11;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef struct packed {
      logic                     func;
      logic [IDX_W-1:0]         index;
      logic signed [DATA_W-1:0] value;
      logic [IDX_W-1:0]         range_low;
      logic [IDX_W-1:0]         range_high;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sum;
      logic                     status;
   } rsp_type;

endpackage

>>> sv/range_sum_segment_tree_top.sv
// range_sum_segment_tree_top: segment tree of 32-bit sums, point write, range query
// depends on rsst_pkg and rsst_ram (element store and node store)
// write: read the old element, then add the difference to each node on the root-to-leaf path; query: stack walk
// summing covered nodes, then a sum step; result strobed in the cycle after the last step; a bad index or range
// is strobed with error status in the cycle after start; one item at a time, limited by one node store read per cycle;
// busy while working; reset: synchronous, then a clearing pass over all 4*MAX_ELEMENTS node entries with busy high
`timescale 1ns / 1ps

module range_sum_segment_tree_top
   import rsst_pkg::*;
#(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_strobe,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SIZE_W-1:0] csr_data
);

   localparam int NODE_DEPTH = 4 * MAX_ELEMENTS;
   localparam int KW  = $clog2(NODE_DEPTH);
   localparam int PW  = $clog2(MAX_ELEMENTS);
   localparam int NW  = $clog2(MAX_ELEMENTS + 1);
   localparam int XW  = ((NW > IDX_W) ? NW : IDX_W) + 1;
   localparam int SW  = ((NW > SIZE_W) ? NW : SIZE_W) + 1;
   localparam int SD  = PW + 1;
   localparam int SIW = $clog2(SD);
   localparam int SPW = $clog2(SD + 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_W_ELEM,
      ST_W_PATH,
      ST_Q_VISIT,
      ST_Q_SUM
   } state_type;

   typedef struct packed {
      logic [PW-1:0] s;
      logic [PW-1:0] e;
      logic [KW-1:0] k;
   } frame_type;

   state_type             state_ff, state_in;
   logic [KW-1:0]         clr_ff, clr_in;
   logic [SIZE_W-1:0]     size_ff, size_in;
   logic [SPW-1:0]        sp_ff, sp_in;
   logic                  pend_ff, pend_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   rsp_type               rsp_ff, rsp_in;
   logic [PW-1:0]         pos_ff, pos_in;
   logic [DATA_W-1:0]     val_ff, val_in;
   logic [DATA_W-1:0]     delta_ff, delta_in;
   logic [PW-1:0]         s_ff, s_in;
   logic [PW-1:0]         e_ff, e_in;
   logic [KW-1:0]         k_ff, k_in;
   logic [XW-1:0]         lo_ff, lo_in;
   logic [XW-1:0]         hi_ff, hi_in;
   logic [DATA_W-1:0]     acc_ff, acc_in;
   frame_type             stack_ff [SD];
   frame_type             stack_in [SD];

   logic                  node_we;
   logic [KW-1:0]         node_waddr;
   logic [DATA_W-1:0]     node_wdata;
   logic [KW-1:0]         node_raddr;
   logic [DATA_W-1:0]     node_rdata;
   logic                  elem_we;
   logic [PW-1:0]         elem_waddr;
   logic [DATA_W-1:0]     elem_wdata;
   logic [PW-1:0]         elem_raddr;
   logic [DATA_W-1:0]     elem_rdata;

   logic [SW-1:0]         size_x;
   logic [NW-1:0]         n_eff;
   logic [XW-1:0]         n_x;
   logic [PW:0]           se_sum;
   logic [PW-1:0]         mid;
   logic [KW-1:0]         k_left;
   logic [KW-1:0]         k_right;
   logic [DATA_W-1:0]     acc_next;
   logic [SPW-1:0]        sp_m1;
   logic                  full_cover;
   logic                  no_cover;
   logic                  do_pop;

   // effective size in use: zero acts as one, clamp to capacity
   always_comb begin
      size_x = SW'(size_ff);
      if (size_ff == '0) begin
         n_eff = NW'(1);
      end else if (size_x > SW'(MAX_ELEMENTS)) begin
         n_eff = NW'(MAX_ELEMENTS);
      end else begin
         n_eff = NW'(size_ff);
      end
   end

   assign n_x      = XW'(n_eff);
   assign se_sum   = {1'b0, s_ff} + {1'b0, e_ff};
   assign mid      = se_sum[PW:1];
   assign k_left   = KW'({k_ff, 1'b1});
   assign k_right  = k_left + KW'(1);
   assign acc_next = acc_ff + (pend_ff ? node_rdata : '0);
   assign sp_m1    = sp_ff - SPW'(1);
   assign full_cover = (lo_ff <= XW'(s_ff)) && (hi_ff >= XW'(e_ff));
   assign no_cover   = (XW'(e_ff) < lo_ff) || (XW'(s_ff) > hi_ff);

   assign size_in   = csr_valid ? csr_data : size_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      sp_in         = sp_ff;
      pend_in       = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      delta_in      = delta_ff;
      s_in          = s_ff;
      e_in          = e_ff;
      k_in          = k_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      acc_in        = acc_ff;
      stack_in      = stack_ff;
      do_pop        = 1'b0;

      node_we    = 1'b0;
      node_waddr = k_ff;
      node_wdata = node_rdata + delta_ff;
      node_raddr = k_ff;
      elem_we    = 1'b0;
      elem_waddr = pos_ff;
      elem_wdata = val_ff;
      elem_raddr = PW'(req_data.index);

      unique case (state_ff)
         ST_CLEAR: begin
            node_we    = 1'b1;
            node_waddr = clr_ff;
            node_wdata = '0;
            elem_we    = (clr_ff < KW'(MAX_ELEMENTS));
            elem_waddr = PW'(clr_ff);
            elem_wdata = '0;
            clr_in     = clr_ff + KW'(1);
            if (clr_ff == KW'(NODE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_data.func == FUNC_WRITE) begin
                  if (XW'(req_data.index) >= n_x) begin
                     rsp_in.sum    = '0;
                     rsp_in.status = STATUS_ERR;
                     rsp_strobe_in = 1'b1;
                  end else begin
                     pos_in   = PW'(req_data.index);
                     val_in   = req_data.value;
                     state_in = ST_W_ELEM;
                  end
               end else begin
                  if ((XW'(req_data.range_high) >= n_x) ||
                      (req_data.range_low > req_data.range_high)) begin
                     rsp_in.sum    = '0;
                     rsp_in.status = STATUS_ERR;
                     rsp_strobe_in = 1'b1;
                  end else begin
                     lo_in    = XW'(req_data.range_low);
                     hi_in    = XW'(req_data.range_high);
                     s_in     = '0;
                     e_in     = PW'(n_eff - NW'(1));
                     k_in     = '0;
                     acc_in   = '0;
                     sp_in    = '0;
                     state_in = ST_Q_VISIT;
                  end
               end
            end
         end
         ST_W_ELEM: begin
            delta_in   = val_ff - elem_rdata;
            elem_we    = 1'b1;
            s_in       = '0;
            e_in       = PW'(n_eff - NW'(1));
            k_in       = '0;
            node_raddr = '0;
            state_in   = ST_W_PATH;
         end
         ST_W_PATH: begin
            // write back node k while reading the next node down the path
            node_we = 1'b1;
            if (s_ff == e_ff) begin
               rsp_in.sum    = '0;
               rsp_in.status = STATUS_OK;
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else if (pos_ff <= mid) begin
               e_in       = mid;
               k_in       = k_left;
               node_raddr = k_left;
            end else begin
               s_in       = mid + PW'(1);
               k_in       = k_right;
               node_raddr = k_right;
            end
         end
         ST_Q_VISIT: begin
            acc_in = acc_next;
            if (full_cover) begin
               node_raddr = k_ff;
               pend_in    = 1'b1;
               do_pop     = 1'b1;
            end else if (no_cover) begin
               do_pop = 1'b1;
            end else begin
               stack_in[sp_ff[SIW-1:0]] = '{s: mid + PW'(1), e: e_ff, k: k_right};
               sp_in = sp_ff + SPW'(1);
               e_in  = mid;
               k_in  = k_left;
            end
            if (do_pop) begin
               if (sp_ff == '0) begin
                  state_in = ST_Q_SUM;
               end else begin
                  s_in  = stack_ff[sp_m1[SIW-1:0]].s;
                  e_in  = stack_ff[sp_m1[SIW-1:0]].e;
                  k_in  = stack_ff[sp_m1[SIW-1:0]].k;
                  sp_in = sp_m1;
               end
            end
         end
         ST_Q_SUM: begin
            rsp_in.sum    = acc_next;
            rsp_in.status = STATUS_OK;
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         size_ff       <= SIZE_RESET;
         sp_ff         <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         size_ff       <= size_in;
         sp_ff         <= sp_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      rsp_ff   <= rsp_in;
      pos_ff   <= pos_in;
      val_ff   <= val_in;
      delta_ff <= delta_in;
      s_ff     <= s_in;
      e_ff     <= e_in;
      k_ff     <= k_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      acc_ff   <= acc_in;
      stack_ff <= stack_in;
   end

   rsst_ram #(
      .WIDTH (DATA_W),
      .DEPTH (NODE_DEPTH)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_waddr),
      .wr_data (node_wdata),
      .rd_addr (node_raddr),
      .rd_data (node_rdata)
   );

   rsst_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_we),
      .wr_addr (elem_waddr),
      .wr_data (elem_wdata),
      .rd_addr (elem_raddr),
      .rd_data (elem_rdata)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> (state_ff == ST_IDLE))
      else $error("response strobe while walk in progress");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SPW'(SD))
      else $error("query stack overflow");

   a_stack_empty_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (sp_ff == '0))
      else $error("query stack not empty at idle");

   a_path_from_elem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_W_PATH) |-> ($past(state_ff) == ST_W_ELEM ||
                                   $past(state_ff) == ST_W_PATH))
      else $error("tree path walk entered without element read");
`endif

endmodule

>>> sv/rsst_ram.sv
// rsst_ram: generic single write port, single read port ram
// read data registered; no dependencies
`timescale 1ns / 1ps

module rsst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
